FILE: hdl/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted
`define JSQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jsq assertion failed");

// Clocked check that also holds during reset
`define JSQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("jsq assertion failed");

`endif

FILE: hdl/jsq_pkg.sv
package jsq_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int IDX_W       = $clog2(MAX_WORKERS);
    localparam int N_W         = $clog2(MAX_WORKERS + 1);
    localparam int CNT_W       = 32;

    localparam logic [CNT_W-1:0] CNT_SIGN  = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic [31:0]      LFSR_TAPS = 32'h8020_0003;

    // Input item functions
    localparam logic [1:0] FUNC_ROUTE    = 2'd0;
    localparam logic [1:0] FUNC_FEEDBACK = 2'd1;
    localparam logic [1:0] FUNC_LOAD     = 2'd2;
    localparam logic [1:0] FUNC_START    = 2'd3;

    // Selection policies
    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_RR     = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_COUNT  = 2'd1;
    localparam logic [1:0] CFG_SLOTS  = 2'd2;
    localparam logic [1:0] CFG_SEED   = 2'd3;

    // Operations carried by the token along the cell row
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_MATCH = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic             inc;
        logic             have;
        logic             found;
        logic             zero;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] key;
        logic [31:0]      ip;
        logic [15:0]      port;
    } t_tok;

    typedef struct packed {
        logic             start;
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic [31:0]      load_ip;
        logic [15:0]      load_port;
        logic [CNT_W-1:0] credit_init;
    } t_bcast;

endpackage

FILE: hdl/jsq_cell.sv
module jsq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [jsq_pkg::IDX_W-1:0]  i_cell_idx,
    input  logic [jsq_pkg::N_W-1:0]    i_n,
    input  jsq_pkg::t_bcast            i_bc,
    input  jsq_pkg::t_tok              i_tok,
    output jsq_pkg::t_tok              o_tok
);

    logic [31:0]              r_ip;
    logic [15:0]              r_port;
    logic [jsq_pkg::CNT_W-1:0] r_credit, n_credit;
    logic [jsq_pkg::CNT_W-1:0] r_sent, n_sent;
    jsq_pkg::t_tok            r_tok, n_tok;

    logic                      active, hit_match, hit_fetch;
    logic [jsq_pkg::CNT_W-1:0] diff, key;

    // Evaluate this worker against the passing token
    always_comb begin
        active    = {1'b0, i_cell_idx} < i_n;
        diff      = r_sent - r_credit;
        key       = diff ^ jsq_pkg::CNT_SIGN;
        hit_match = i_tok.valid && (i_tok.op == jsq_pkg::OP_MATCH) && active
                    && !i_tok.found && (r_ip == i_tok.ip) && (r_port == i_tok.port);
        hit_fetch = i_tok.valid && (i_tok.op == jsq_pkg::OP_FETCH)
                    && (i_tok.idx == i_cell_idx);
        n_tok      = i_tok;
        n_tok.zero = 1'b0;
        case (i_tok.op)
            jsq_pkg::OP_SCAN: begin
                if (active) begin
                    if (!i_tok.have || key < i_tok.key) begin
                        n_tok.have = 1'b1;
                        n_tok.key  = key;
                        n_tok.idx  = i_cell_idx;
                    end
                    n_tok.zero = (diff == '0);
                end
            end
            jsq_pkg::OP_MATCH: begin
                if (hit_match) begin
                    n_tok.found = 1'b1;
                    n_tok.idx   = i_cell_idx;
                end
            end
            jsq_pkg::OP_FETCH: begin
                if (hit_fetch) begin
                    n_tok.ip   = r_ip;
                    n_tok.port = r_port;
                end
            end
            default: ;
        endcase
        if (!i_tok.valid) begin
            n_tok.valid = 1'b0;
        end
    end

    // Update counters on start or on a hit
    always_comb begin
        n_credit = r_credit;
        n_sent   = r_sent;
        if (i_bc.start) begin
            n_credit = i_bc.credit_init;
            n_sent   = '0;
        end else begin
            if (hit_match && i_tok.inc) begin
                n_credit = r_credit + 1'b1;
            end
            if (hit_fetch && i_tok.inc) begin
                n_sent = r_sent + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= '0;
            r_credit <= '0;
            r_sent   <= '0;
        end else begin
            r_tok    <= n_tok;
            r_credit <= n_credit;
            r_sent   <= n_sent;
        end
    end

    // Hold the worker address
    always_ff @(posedge i_clk) begin
        if (i_bc.load && (i_bc.load_idx == i_cell_idx)) begin
            r_ip   <= i_bc.load_ip;
            r_port <= i_bc.load_port;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: hdl/jsq_mod_unit.sv
module jsq_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [31:0]               i_dividend,
    input  logic [jsq_pkg::N_W-1:0]   i_divisor,
    output logic                      o_done,
    output logic [jsq_pkg::IDX_W-1:0] o_rem
);

    logic                    r_busy;
    logic [4:0]              r_cnt;
    logic [31:0]             r_q;
    logic [jsq_pkg::N_W-1:0] r_rem;
    logic                    r_done;
    logic [jsq_pkg::N_W:0]   trial;

    // One restoring remainder step per cycle while busy
    always_comb begin
        trial = {r_rem, r_q[31]};
        if (trial >= {1'b0, i_divisor}) begin
            trial = trial - {1'b0, i_divisor};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], 1'b0};
            r_rem <= trial[jsq_pkg::N_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[jsq_pkg::IDX_W-1:0];

endmodule

FILE: hdl/jsq_worker_selector_unit.sv
// Join-shortest-queue worker selector.
// Input: an item is transferred when i_start is high and o_busy is low.
// Load and start items finish in the transfer cycle and give no result.
// Route requests and feedback each give one result, shown for one cycle
// with o_valid; the receiver cannot stall it and it is never repeated.
// Every table lookup rides a token through a row of 64 worker cells,
// one cell per cycle. Steps to the result: feedback, a match pass;
// i_route_kind set, a fetch pass of worker 0; random or round-robin,
// the remainder unit, then a fetch pass; join-shortest-queue, a pop if
// an idle worker is stacked, else a scan pass, then a pop if it stacked
// one, then a fetch pass. One item is in flight at a time; o_busy drops
// with the result strobe, so the next item can transfer at the edge that
// ends the strobe. Configuration writes take effect at once; the user
// must make them while idle, which the block does not enforce. Reset
// restores the register defaults, clears all counters, the idle stack
// depth and the round-robin counter and loads the LFSR with 1.
`include "assert_macros.svh"

module jsq_worker_selector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_func,
    input  logic        i_route_kind,
    input  logic [31:0] i_source_ip,
    input  logic [15:0] i_source_port,
    input  logic [5:0]  i_entry_index,
    input  logic [31:0] i_entry_ip,
    input  logic [15:0] i_entry_port,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_route_valid,
    output logic [5:0]  o_target_index,
    output logic [31:0] o_worker_ip,
    output logic [15:0] o_worker_port,
    output logic        o_unmatched
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_SDONE = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_POPW  = 3'd5;

    localparam int MW = jsq_pkg::MAX_WORKERS;

    // Configuration registers
    logic [1:0]  r_policy;
    logic [6:0]  r_count;
    logic [15:0] r_slots;
    logic [31:0] r_seed;

    logic [2:0]                r_state, n_state;
    logic [jsq_pkg::N_W-1:0]   r_depth, n_depth;
    logic [15:0]               r_rr, n_rr;
    logic [31:0]               r_lfsr, n_lfsr;
    logic [jsq_pkg::IDX_W-1:0] r_w, n_w;
    logic [jsq_pkg::IDX_W-1:0] r_pos, n_pos;
    jsq_pkg::t_tok             r_inj, n_inj;

    logic                      r_out_valid, n_out_valid;
    logic                      r_route_valid, n_route_valid;
    logic [jsq_pkg::IDX_W-1:0] r_tidx, n_tidx;
    logic [31:0]               r_tip, n_tip;
    logic [15:0]               r_tport, n_tport;
    logic                      r_unm, n_unm;

    logic [jsq_pkg::IDX_W-1:0] r_stack [MW];
    logic [jsq_pkg::IDX_W-1:0] r_rd;

    logic                      accept, push, pop, take_req;
    logic [jsq_pkg::N_W-1:0]   n_active;
    logic [31:0]               lfsr_step, div_dividend;
    logic                      div_start, div_done;
    logic [jsq_pkg::IDX_W-1:0] div_rem;
    jsq_pkg::t_bcast           bc;
    jsq_pkg::t_tok             w_tok [MW+1];
    logic [MW-1:0]             w_zero;
    jsq_pkg::t_tok             last_tok;

    assign accept   = i_start && (r_state == S_IDLE);
    assign last_tok = w_tok[MW];
    assign take_req = accept && ((i_func == jsq_pkg::FUNC_ROUTE)
                                 || (i_func == jsq_pkg::FUNC_FEEDBACK));

    // Clamp the worker count to 1..MAX_WORKERS
    always_comb begin
        if (r_count == '0) begin
            n_active = jsq_pkg::N_W'(1);
        end else if ({1'b0, r_count} > 8'(MW)) begin
            n_active = jsq_pkg::N_W'(MW);
        end else begin
            n_active = r_count[jsq_pkg::N_W-1:0];
        end
    end

    // Step the Galois LFSR once
    always_comb begin
        lfsr_step = {1'b0, r_lfsr[31:1]};
        if (r_lfsr[0]) begin
            lfsr_step = lfsr_step ^ jsq_pkg::LFSR_TAPS;
        end
    end

    // Broadcast start and table loads to the row
    always_comb begin
        bc.start       = accept && (i_func == jsq_pkg::FUNC_START);
        bc.load        = accept && (i_func == jsq_pkg::FUNC_LOAD);
        bc.load_idx    = i_entry_index;
        bc.load_ip     = i_entry_ip;
        bc.load_port   = i_entry_port;
        bc.credit_init = jsq_pkg::CNT_W'(r_slots);
    end

    assign div_start = accept && (i_func == jsq_pkg::FUNC_ROUTE) && !i_route_kind
                       && !r_policy[1];
    assign div_dividend = (r_policy == jsq_pkg::POL_RANDOM) ? lfsr_step : {16'd0, r_rr};

    jsq_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (n_active),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Row of worker cells, token handed one cell per cycle
    assign w_tok[0] = r_inj;
    for (genvar gi = 0; gi < MW; gi++) begin : g_cell
        jsq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (jsq_pkg::IDX_W'(gi)),
            .i_n        (n_active),
            .i_bc       (bc),
            .i_tok      (w_tok[gi]),
            .o_tok      (w_tok[gi+1])
        );
        assign w_zero[gi] = w_tok[gi+1].valid && w_tok[gi+1].zero;
    end

    assign push = (r_state == S_WAIT) && (|w_zero) && (r_depth < jsq_pkg::N_W'(MW));
    assign pop  = (r_state == S_POP);

    // Sequence one item
    always_comb begin
        n_state       = r_state;
        n_depth       = r_depth;
        n_rr          = r_rr;
        n_lfsr        = r_lfsr;
        n_w           = r_w;
        n_pos         = r_pos + 1'b1;
        n_inj         = '0;
        n_out_valid   = 1'b0;
        n_route_valid = r_route_valid;
        n_tidx        = r_tidx;
        n_tip         = r_tip;
        n_tport       = r_tport;
        n_unm         = r_unm;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        jsq_pkg::FUNC_START: begin
                            n_depth = '0;
                            n_rr    = '0;
                            n_lfsr  = r_seed;
                        end
                        jsq_pkg::FUNC_FEEDBACK: begin
                            n_inj.valid = 1'b1;
                            n_inj.op    = jsq_pkg::OP_MATCH;
                            n_inj.inc   = r_policy[1];
                            n_inj.ip    = i_source_ip;
                            n_inj.port  = i_source_port;
                            n_pos       = '0;
                            n_state     = S_WAIT;
                        end
                        jsq_pkg::FUNC_ROUTE: begin
                            if (i_route_kind) begin
                                n_w         = '0;
                                n_inj.valid = 1'b1;
                                n_inj.op    = jsq_pkg::OP_FETCH;
                                n_pos       = '0;
                                n_state     = S_WAIT;
                            end else if (r_policy == jsq_pkg::POL_RANDOM) begin
                                n_lfsr  = lfsr_step;
                                n_state = S_DIV;
                            end else if (r_policy == jsq_pkg::POL_RR) begin
                                n_rr    = r_rr + 1'b1;
                                n_state = S_DIV;
                            end else if (r_depth != '0) begin
                                n_state = S_POP;
                            end else begin
                                n_inj.valid = 1'b1;
                                n_inj.op    = jsq_pkg::OP_SCAN;
                                n_pos       = '0;
                                n_state     = S_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_w         = div_rem;
                    n_inj.valid = 1'b1;
                    n_inj.op    = jsq_pkg::OP_FETCH;
                    n_inj.idx   = div_rem;
                    n_pos       = '0;
                    n_state     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (push) begin
                    n_depth = r_depth + 1'b1;
                end
                if (last_tok.valid) begin
                    case (last_tok.op)
                        jsq_pkg::OP_SCAN: begin
                            n_w     = last_tok.idx;
                            n_state = S_SDONE;
                        end
                        jsq_pkg::OP_MATCH: begin
                            n_out_valid   = 1'b1;
                            n_route_valid = 1'b0;
                            n_tidx        = '0;
                            n_tip         = '0;
                            n_tport       = '0;
                            n_unm         = !last_tok.found;
                            n_state       = S_IDLE;
                        end
                        default: begin
                            n_out_valid   = 1'b1;
                            n_route_valid = 1'b1;
                            n_tidx        = r_w;
                            n_tip         = last_tok.ip;
                            n_tport       = last_tok.port;
                            n_unm         = 1'b0;
                            n_state       = S_IDLE;
                        end
                    endcase
                end
            end
            S_SDONE: begin
                if (r_depth != '0) begin
                    n_state = S_POP;
                end else begin
                    n_inj.valid = 1'b1;
                    n_inj.op    = jsq_pkg::OP_FETCH;
                    n_inj.inc   = 1'b1;
                    n_inj.idx   = r_w;
                    n_pos       = '0;
                    n_state     = S_WAIT;
                end
            end
            S_POP: begin
                n_depth = r_depth - 1'b1;
                n_state = S_POPW;
            end
            S_POPW: begin
                n_w         = r_rd;
                n_inj.valid = 1'b1;
                n_inj.op    = jsq_pkg::OP_FETCH;
                n_inj.inc   = 1'b1;
                n_inj.idx   = r_rd;
                n_pos       = '0;
                n_state     = S_WAIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_rr        <= '0;
            r_lfsr      <= 32'd1;
            r_inj       <= '0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_rr        <= n_rr;
            r_lfsr      <= n_lfsr;
            r_inj       <= n_inj;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    // Result and scratch payload
    always_ff @(posedge i_clk) begin
        r_w           <= n_w;
        r_route_valid <= n_route_valid;
        r_tidx        <= n_tidx;
        r_tip         <= n_tip;
        r_tport       <= n_tport;
        r_unm         <= n_unm;
    end

    // Idle worker stack: push during a scan, pop with registered read.
    // A cell's flag shows in the cycle after it is visited, so the cell index
    // trails the position count by one.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_depth[jsq_pkg::IDX_W-1:0]] <= r_pos - 1'b1;
        end
        if (pop) begin
            r_rd <= r_stack[(r_depth[jsq_pkg::IDX_W-1:0]) - 1'b1];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 2'd2;
            r_count  <= 7'd1;
            r_slots  <= '0;
            r_seed   <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jsq_pkg::CFG_POLICY: r_policy <= i_cfg_data[1:0];
                jsq_pkg::CFG_COUNT:  r_count  <= i_cfg_data[6:0];
                jsq_pkg::CFG_SLOTS:  r_slots  <= i_cfg_data[15:0];
                jsq_pkg::CFG_SEED:   r_seed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_route_valid  = r_route_valid;
    assign o_target_index = r_tidx;
    assign o_worker_ip    = r_tip;
    assign o_worker_port  = r_tport;
    assign o_unmatched    = r_unm;

    `JSQ_ASSERT(a_result_after_work, i_clk, i_rst_n, o_valid |-> $past(o_busy))
    `JSQ_ASSERT(a_route_not_flagged, i_clk, i_rst_n, (o_valid && o_route_valid) |-> !o_unmatched)
    `JSQ_ASSERT(a_request_goes_busy, i_clk, i_rst_n, take_req |=> o_busy)
    `JSQ_ASSERT(a_depth_bound, i_clk, i_rst_n, r_depth <= jsq_pkg::N_W'(MW))

endmodule
